/* src/gnod_pkg.sv */
package gnod_pkg;

	localparam int unsigned MAX_COLUMNS = 4096;
	localparam int unsigned MAX_ROWS    = 4096;

	localparam int unsigned COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int unsigned ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int unsigned POS_W = (COL_W > ROW_W) ? COL_W : ROW_W;

	localparam int unsigned OCC_W        = 8;
	localparam int unsigned COORD_W      = 32;
	localparam int unsigned CELL_SIZE_W  = 24;
	localparam int unsigned GRID_WIDTH_W = 13;
	localparam int unsigned MAX_DIST_W   = 24;
	localparam int unsigned DIST_W       = 32;

	localparam int unsigned MUL_W    = 32;
	localparam int unsigned PROD_W   = POS_W + CELL_SIZE_W;
	localparam int unsigned DIFF_W   = ((PROD_W > COORD_W + 1) ? PROD_W : COORD_W + 1) + 2;
	localparam int unsigned SQ_W     = 2 * MUL_W;
	localparam int unsigned MAXSQ_W  = 2 * MAX_DIST_W;
	localparam int unsigned WCMP_W   = (COL_W + 1 > GRID_WIDTH_W) ? COL_W + 1 : GRID_WIDTH_W;
	localparam int unsigned ROOT_K_W = 5;

	localparam int unsigned PADDR_W = 5;
	localparam int unsigned PDATA_W = 32;

	localparam logic [CELL_SIZE_W-1:0]  CELL_SIZE_RST  = CELL_SIZE_W'(3277);
	localparam logic [GRID_WIDTH_W-1:0] GRID_WIDTH_RST = GRID_WIDTH_W'(4096);
	localparam logic [MAX_DIST_W-1:0]   MAX_DIST_RST   = MAX_DIST_W'(393216);
	localparam logic [MAXSQ_W-1:0]      MAX_SQ_RST     = MAXSQ_W'(MAX_DIST_RST) * MAXSQ_W'(MAX_DIST_RST);

	typedef logic [2:0] reg_idx_t;

	localparam reg_idx_t REG_ROBOT_X       = 3'd0;
	localparam reg_idx_t REG_ROBOT_Y       = 3'd1;
	localparam reg_idx_t REG_GRID_ORIGIN_X = 3'd2;
	localparam reg_idx_t REG_GRID_ORIGIN_Y = 3'd3;
	localparam reg_idx_t REG_CELL_SIZE     = 3'd4;
	localparam reg_idx_t REG_GRID_WIDTH    = 3'd5;
	localparam reg_idx_t REG_MAX_DISTANCE  = 3'd6;

endpackage

/* src/gnod_if.sv */
interface gnod_grid_if import gnod_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OCC_W-1:0] occupancy;
	logic                    last_cell;

	modport source (output valid, output occupancy, output last_cell, input ready);
	modport sink   (input valid, input occupancy, input last_cell, output ready);
endinterface

interface gnod_result_if import gnod_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] nearest_distance;

	modport source (output valid, output nearest_distance, input ready);
	modport sink   (input valid, input nearest_distance, output ready);
endinterface

/* src/grid_nearest_obstacle_distance.sv */
// Streams an occupancy grid one cell per beat in row-major order and, on the beat marked
// last_cell, returns the distance (Q16.16 m) from the robot to the nearest occupied cell, or
// max_distance when none is closer. A free or unknown cell needs no further work; an
// occupied cell stalls the grid channel while its position products and both squares go
// one after another through a single 32x32 multiplier. The last cell also runs the
// bit-serial square root (32 steps plus load and hand-off). A write of max_distance keeps
// the grid channel busy while the new squared limit goes through the multiplier. A finished
// result sits in an output register, so the next grid can start while it waits to be taken.
module grid_nearest_obstacle_distance import gnod_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	gnod_grid_if.sink          grid,
	gnod_result_if.source      result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MUL   = 4'd1;
	localparam logic [3:0] S_DIF   = 4'd2;
	localparam logic [3:0] S_ABS   = 4'd3;
	localparam logic [3:0] S_SQ    = 4'd4;
	localparam logic [3:0] S_SUM   = 4'd5;
	localparam logic [3:0] S_LOAD  = 4'd6;
	localparam logic [3:0] S_RINIT = 4'd7;
	localparam logic [3:0] S_ROOT  = 4'd8;
	localparam logic [3:0] S_EMIT  = 4'd9;

	logic [3:0] state_q;
	logic       reload_q;
	logic       axis_q;

	logic signed [COORD_W-1:0] robot_x_q, robot_y_q, origin_x_q, origin_y_q;
	logic [CELL_SIZE_W-1:0]    cell_size_q;
	logic [GRID_WIDTH_W-1:0]   grid_width_q;
	logic [MAX_DIST_W-1:0]     max_dist_q;
	logic [MAXSQ_W-1:0]        max_sq_q;
	logic [SQ_W-1:0]           lsd_q;

	logic [COL_W-1:0] col_q, item_col_q;
	logic [ROW_W-1:0] row_q, item_row_q;
	logic             last_q;

	logic [SQ_W-1:0]          prod_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic [DIFF_W-1:0]        abs_q;
	logic                     sat_q;
	logic [SQ_W-1:0]          acc_q;
	logic [SQ_W-1:0]          v_q, res_q;
	logic [ROOT_K_W-1:0]      k_q;

	logic              out_valid_q;
	logic [DIST_W-1:0] out_data_q;

	logic cfg_wr;
	logic in_acc;
	logic occupied;
	logic emit_go;

	logic [MUL_W-1:0]  mul_a, mul_b;
	logic [SQ_W-1:0]   mul_p;
	logic [SQ_W-1:0]   sq_val;
	logic [SQ_W:0]     sum_w;
	logic [SQ_W-1:0]   total;
	logic [SQ_W-1:0]   rbit, trial;
	logic [SQ_W:0]     rdiff;
	logic [WCMP_W-1:0] width_eff, col_inc;
	logic [ROW_W:0]    row_inc;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign in_acc   = grid.valid && grid.ready;
	assign occupied = !grid.occupancy[OCC_W-1] && (grid.occupancy != '0);
	assign emit_go  = (state_q == S_EMIT) && (!out_valid_q || result.ready);

	assign grid.ready              = (state_q == S_IDLE) && !reload_q;
	assign result.valid            = out_valid_q;
	assign result.nearest_distance = out_data_q;

	always_comb begin
		prdata = '0;
		unique case (paddr[4:2])
			REG_ROBOT_X:       prdata = robot_x_q;
			REG_ROBOT_Y:       prdata = robot_y_q;
			REG_GRID_ORIGIN_X: prdata = origin_x_q;
			REG_GRID_ORIGIN_Y: prdata = origin_y_q;
			REG_CELL_SIZE:     prdata = PDATA_W'(cell_size_q);
			REG_GRID_WIDTH:    prdata = PDATA_W'(grid_width_q);
			REG_MAX_DISTANCE:  prdata = PDATA_W'(max_dist_q);
			default:           prdata = '0;
		endcase
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_IDLE: begin
				mul_a = MUL_W'(max_dist_q);
				mul_b = MUL_W'(max_dist_q);
			end
			S_MUL: begin
				mul_a = axis_q ? MUL_W'(item_row_q) : MUL_W'(item_col_q);
				mul_b = MUL_W'(cell_size_q);
			end
			S_SQ: begin
				mul_a = abs_q[MUL_W-1:0];
				mul_b = abs_q[MUL_W-1:0];
			end
			default: ;
		endcase
	end

	assign mul_p  = SQ_W'(mul_a) * SQ_W'(mul_b);
	assign sq_val = sat_q ? '1 : prod_q;
	assign sum_w  = {1'b0, acc_q} + {1'b0, sq_val};
	assign total  = sum_w[SQ_W] ? '1 : sum_w[SQ_W-1:0];

	assign rbit  = SQ_W'(1) << {k_q, 1'b0};
	assign trial = res_q + rbit;
	assign rdiff = {1'b0, v_q} - {1'b0, trial};

	always_comb begin
		width_eff = WCMP_W'(grid_width_q);
		if (grid_width_q == '0 || WCMP_W'(grid_width_q) > WCMP_W'(MAX_COLUMNS)) begin
			width_eff = WCMP_W'(MAX_COLUMNS);
		end
	end

	assign col_inc = WCMP_W'(col_q) + WCMP_W'(1);
	assign row_inc = {1'b0, row_q} + (ROW_W + 1)'(1);

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			reload_q     <= 1'b0;
			axis_q       <= 1'b0;
			robot_x_q    <= '0;
			robot_y_q    <= '0;
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			cell_size_q  <= CELL_SIZE_RST;
			grid_width_q <= GRID_WIDTH_RST;
			max_dist_q   <= MAX_DIST_RST;
			max_sq_q     <= MAX_SQ_RST;
			lsd_q        <= SQ_W'(MAX_SQ_RST);
			col_q        <= '0;
			row_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			if (in_acc) begin
				if (grid.last_cell) begin
					col_q <= '0;
					row_q <= '0;
				end else if (col_inc >= width_eff) begin
					col_q <= '0;
					row_q <= (row_inc >= (ROW_W + 1)'(MAX_ROWS)) ? '0 : row_inc[ROW_W-1:0];
				end else begin
					col_q <= col_inc[COL_W-1:0];
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (reload_q) begin
						state_q <= S_LOAD;
					end else if (in_acc) begin
						axis_q <= 1'b0;
						if (occupied) begin
							state_q <= S_MUL;
						end else if (grid.last_cell) begin
							state_q <= S_RINIT;
						end
					end
				end
				S_MUL:   state_q <= S_DIF;
				S_DIF:   state_q <= S_ABS;
				S_ABS:   state_q <= S_SQ;
				S_SQ: begin
					if (axis_q) begin
						state_q <= S_SUM;
					end else begin
						axis_q  <= 1'b1;
						state_q <= S_MUL;
					end
				end
				S_SUM: begin
					if (total < lsd_q) begin
						lsd_q <= total;
					end
					state_q <= last_q ? S_RINIT : S_IDLE;
				end
				S_LOAD: begin
					max_sq_q <= prod_q[MAXSQ_W-1:0];
					lsd_q    <= SQ_W'(prod_q[MAXSQ_W-1:0]);
					reload_q <= 1'b0;
					state_q  <= S_IDLE;
				end
				S_RINIT: state_q <= S_ROOT;
				S_ROOT: begin
					if (k_q == '0) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						lsd_q   <= SQ_W'(max_sq_q);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (cfg_wr) begin
				unique case (paddr[4:2])
					REG_ROBOT_X:       robot_x_q    <= pwdata;
					REG_ROBOT_Y:       robot_y_q    <= pwdata;
					REG_GRID_ORIGIN_X: origin_x_q   <= pwdata;
					REG_GRID_ORIGIN_Y: origin_y_q   <= pwdata;
					REG_CELL_SIZE:     cell_size_q  <= pwdata[CELL_SIZE_W-1:0];
					REG_GRID_WIDTH:    grid_width_q <= pwdata[GRID_WIDTH_W-1:0];
					REG_MAX_DISTANCE: begin
						max_dist_q <= pwdata[MAX_DIST_W-1:0];
						reload_q   <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_p;

		if (in_acc) begin
			item_col_q <= col_q;
			item_row_q <= row_q;
			last_q     <= grid.last_cell;
		end

		unique case (state_q)
			S_MUL: begin
				if (axis_q) begin
					acc_q <= sq_val;
				end
			end
			S_DIF: begin
				if (axis_q) begin
					diff_q <= DIFF_W'(robot_y_q) - DIFF_W'(origin_y_q)
						- DIFF_W'(prod_q[PROD_W-1:0]);
				end else begin
					diff_q <= DIFF_W'(robot_x_q) - DIFF_W'(origin_x_q)
						- DIFF_W'(prod_q[PROD_W-1:0]);
				end
			end
			S_ABS: abs_q <= diff_q[DIFF_W-1] ? DIFF_W'(-diff_q) : DIFF_W'(diff_q);
			S_SQ:  sat_q <= |abs_q[DIFF_W-1:MUL_W];
			S_RINIT: begin
				v_q   <= lsd_q;
				res_q <= '0;
				k_q   <= '1;
			end
			S_ROOT: begin
				if (!rdiff[SQ_W]) begin
					v_q   <= rdiff[SQ_W-1:0];
					res_q <= (res_q >> 1) + rbit;
				end else begin
					res_q <= res_q >> 1;
				end
				k_q <= k_q - ROOT_K_W'(1);
			end
			S_EMIT: begin
				if (emit_go) begin
					out_data_q <= res_q[DIST_W-1:0];
				end
			end
			default: ;
		endcase
	end

	a_last_clears_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && grid.last_cell) |=> (col_q == '0 && row_q == '0))
		else $error("position not cleared after last cell");

	a_min_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		lsd_q <= SQ_W'(max_sq_q))
		else $error("running minimum above squared limit");

	a_root_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROOT && k_q == '0) |=> (state_q == S_EMIT))
		else $error("square root did not hand off");

	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_EMIT))
		else $error("result raised outside emit");

endmodule

/* bench/nearest_distance_checker.sv */
`timescale 1ns / 1ps

module nearest_distance_checker import gnod_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    grid_valid,
	input  logic                    grid_ready,
	input  logic signed [OCC_W-1:0] occupancy,
	input  logic                    last_cell,
	input  logic                    dist_valid,
	input  logic                    dist_ready,
	input  logic [DIST_W-1:0]       nearest_distance,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [PADDR_W-1:0]      paddr,
	input  logic [PDATA_W-1:0]      pwdata,
	input  logic [PDATA_W-1:0]      prdata,
	input  logic                    pready,
	output int                      mismatches,
	output int                      awaiting
);

	logic signed [COORD_W-1:0] robot_x;
	logic signed [COORD_W-1:0] robot_y;
	logic signed [COORD_W-1:0] origin_x;
	logic signed [COORD_W-1:0] origin_y;
	logic [CELL_SIZE_W-1:0]    cell_size;
	logic [GRID_WIDTH_W-1:0]   grid_width;
	logic [MAX_DIST_W-1:0]     max_distance;

	logic [COL_W-1:0] cur_col;
	logic [ROW_W-1:0] cur_row;
	logic [63:0]      best_sq;

	logic [DIST_W-1:0] distance_queue[$];
	int fail_count = 0;
	int waiting = 0;

	assign mismatches = fail_count;
	assign awaiting   = waiting;

	function automatic logic [63:0] limit_sq(input logic [MAX_DIST_W-1:0] d);
		return 64'(d) * 64'(d);
	endfunction

	function automatic logic [63:0] clamp_square(input longint d);
		logic [63:0] mag;
		mag = (d < 0) ? 64'(-d) : 64'(d);
		if (mag > 64'hFFFF_FFFF)
			return '1;
		return mag * mag;
	endfunction

	function automatic logic [63:0] axis_sq(input logic signed [COORD_W-1:0] robot,
			input logic signed [COORD_W-1:0] origin, input logic [POS_W-1:0] index,
			input logic [CELL_SIZE_W-1:0] size);
		longint pos;
		pos = longint'(origin) + longint'(index) * longint'(size);
		return clamp_square(longint'(robot) - pos);
	endfunction

	function automatic logic [DIST_W-1:0] floor_sqrt(input logic [63:0] v);
		logic [DIST_W-1:0] root;
		logic [DIST_W-1:0] trial;
		root = '0;
		for (int b = DIST_W - 1; b >= 0; b--) begin
			trial = root | (DIST_W'(1) << b);
			if (64'(trial) * 64'(trial) <= v)
				root = trial;
		end
		return root;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		logic [63:0]             sx;
		logic [63:0]             sy;
		logic [64:0]             total;
		logic [GRID_WIDTH_W-1:0] span;
		logic [COL_W:0]          next_col;
		logic [PDATA_W-1:0]      shadow;
		logic                    known;
		logic [DIST_W-1:0]       want;
		reg_idx_t                idx;
		if (!arst_n) begin
			robot_x      = '0;
			robot_y      = '0;
			origin_x     = '0;
			origin_y     = '0;
			cell_size    = CELL_SIZE_RST;
			grid_width   = GRID_WIDTH_RST;
			max_distance = MAX_DIST_RST;
			cur_col      = '0;
			cur_row      = '0;
			best_sq      = limit_sq(MAX_DIST_RST);
			distance_queue.delete();
		end else begin
			if (psel && penable && pready) begin
				idx = reg_idx_t'(paddr[PADDR_W-1:2]);
				if (pwrite) begin
					case (idx)
						REG_ROBOT_X:       robot_x = pwdata;
						REG_ROBOT_Y:       robot_y = pwdata;
						REG_GRID_ORIGIN_X: origin_x = pwdata;
						REG_GRID_ORIGIN_Y: origin_y = pwdata;
						REG_CELL_SIZE:     cell_size = pwdata[CELL_SIZE_W-1:0];
						REG_GRID_WIDTH:    grid_width = pwdata[GRID_WIDTH_W-1:0];
						REG_MAX_DISTANCE: begin
							max_distance = pwdata[MAX_DIST_W-1:0];
							best_sq      = limit_sq(max_distance);
						end
						default: ;
					endcase
				end else begin
					known = 1'b1;
					case (idx)
						REG_ROBOT_X:       shadow = robot_x;
						REG_ROBOT_Y:       shadow = robot_y;
						REG_GRID_ORIGIN_X: shadow = origin_x;
						REG_GRID_ORIGIN_Y: shadow = origin_y;
						REG_CELL_SIZE:     shadow = PDATA_W'(cell_size);
						REG_GRID_WIDTH:    shadow = PDATA_W'(grid_width);
						REG_MAX_DISTANCE:  shadow = PDATA_W'(max_distance);
						default: begin
							shadow = '0;
							known  = 1'b0;
						end
					endcase
					if (known && prdata !== shadow) begin
						$error("prdata: expected %0h, actual %0h", shadow, prdata);
						fail_count++;
					end
				end
			end

			if (grid_valid && grid_ready) begin
				if (occupancy > 0) begin
					sx    = axis_sq(robot_x, origin_x, cur_col, cell_size);
					sy    = axis_sq(robot_y, origin_y, cur_row, cell_size);
					total = {1'b0, sx} + {1'b0, sy};
					if (total[64])
						total[63:0] = '1;
					if (total[63:0] < best_sq)
						best_sq = total[63:0];
				end
				if (last_cell) begin
					distance_queue.push_back(floor_sqrt(best_sq));
					cur_col = '0;
					cur_row = '0;
					best_sq = limit_sq(max_distance);
				end else begin
					span = (grid_width == 0 || grid_width > MAX_COLUMNS) ?
						GRID_WIDTH_W'(MAX_COLUMNS) : grid_width;
					next_col = {1'b0, cur_col} + 1'b1;
					if (GRID_WIDTH_W'(next_col) >= span) begin
						cur_col = '0;
						cur_row = (cur_row == ROW_W'(MAX_ROWS - 1)) ? '0 : cur_row + 1'b1;
					end else begin
						cur_col = next_col[COL_W-1:0];
					end
				end
			end

			if (dist_valid && dist_ready) begin
				if (distance_queue.size() == 0) begin
					$error("nearest_distance: unexpected beat, actual %0d", nearest_distance);
					fail_count++;
				end else begin
					want = distance_queue.pop_front();
					if (nearest_distance !== want) begin
						$error("nearest_distance: expected %0d, actual %0d", want,
							nearest_distance);
						fail_count++;
					end
				end
			end
		end
		waiting = distance_queue.size();
	end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import gnod_pkg::*;

	localparam reg_idx_t REG_UNUSED   = 3'd7;
	localparam int       RANDOM_CELLS = 1550;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int mismatches;
	int awaiting;
	int burst_left;
	int cells_sent;

	gnod_grid_if   grid_bus();
	gnod_result_if result_bus();

	grid_nearest_obstacle_distance uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.grid    (grid_bus),
		.result  (result_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	nearest_distance_checker distance_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.grid_valid       (grid_bus.valid),
		.grid_ready       (grid_bus.ready),
		.occupancy        (grid_bus.occupancy),
		.last_cell        (grid_bus.last_cell),
		.dist_valid       (result_bus.valid),
		.dist_ready       (result_bus.ready),
		.nearest_distance (result_bus.nearest_distance),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.mismatches       (mismatches),
		.awaiting         (awaiting)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#60_000_000;
		$display("Mismatches found");
		$finish;
	end

	// result stall pattern
	initial begin
		int mode;
		int span;
		int tick;
		result_bus.ready = 1'b0;
		tick = 0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 300);
			repeat (span) begin
				@(posedge clk);
				tick++;
				case (mode)
					0:       result_bus.ready <= 1'b1;
					1:       result_bus.ready <= ($urandom_range(0, 1) == 1);
					2:       result_bus.ready <= ($urandom_range(0, 7) == 0);
					default: result_bus.ready <= (tick % 32 >= 28);
				endcase
			end
		end
	end

	task automatic apb_access(input logic write, input reg_idx_t idx,
			input logic [PDATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic read_all();
		for (int r = REG_ROBOT_X; r <= REG_MAX_DISTANCE; r++)
			apb_access(1'b0, reg_idx_t'(r), '0);
	endtask

	// cells without a result may still be in flight: drain, then hold off
	task automatic pause_until_idle();
		grid_bus.valid <= 1'b0;
		@(posedge clk);
		wait (awaiting == 0);
		repeat (60) @(posedge clk);
	endtask

	task automatic send_cell(input logic [OCC_W-1:0] occ, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) :
				$urandom_range(1, 20);
			if (gap > 0) begin
				grid_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		grid_bus.valid     <= 1'b1;
		grid_bus.occupancy <= occ;
		grid_bus.last_cell <= last;
		@(posedge clk);
		while (!grid_bus.ready) @(posedge clk);
	endtask

	function automatic logic [OCC_W-1:0] pick_occupancy(input int busy_pct);
		if ($urandom_range(0, 99) < busy_pct)
			return OCC_W'($urandom_range(1, 127));
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return '1;
			default: return OCC_W'($urandom_range(128, 255));
		endcase
	endfunction

	function automatic logic [PDATA_W-1:0] pick_cell_size();
		case ($urandom_range(0, 5))
			0:       return 1;
			1:       return 32'h00FF_FFFF;
			2:       return $urandom_range(1, 4096);
			default: return $urandom_range(1, 2 * 65536);
		endcase
	endfunction

	function automatic logic [PDATA_W-1:0] pick_width();
		case ($urandom_range(0, 9))
			0:       return 0;
			1:       return MAX_COLUMNS;
			2:       return 8191;
			3:       return $urandom_range(0, 8191);
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	function automatic logic [PDATA_W-1:0] pick_max_distance();
		case ($urandom_range(0, 5))
			0:       return 0;
			1:       return 32'h00FF_FFFF;
			2:       return $urandom & 32'h00FF_FFFF;
			default: return $urandom_range(1, 20 * 65536);
		endcase
	endfunction

	function automatic logic [PDATA_W-1:0] grid_offset();
		return $urandom_range(0, 28 * 65536) - 4 * 65536;
	endfunction

	task automatic randomize_setup();
		logic [PDATA_W-1:0] rx;
		logic [PDATA_W-1:0] ry;
		bit                 noise;
		noise = ($urandom_range(0, 9) == 0);
		rx    = $urandom;
		ry    = $urandom;
		if ($urandom_range(0, 3) != 0) begin
			apb_access(1'b1, REG_ROBOT_X, rx);
			apb_access(1'b1, REG_ROBOT_Y, ry);
			apb_access(1'b1, REG_GRID_ORIGIN_X, noise ? $urandom : rx - grid_offset());
			apb_access(1'b1, REG_GRID_ORIGIN_Y, noise ? $urandom : ry - grid_offset());
		end
		if ($urandom_range(0, 3) != 0)
			apb_access(1'b1, REG_CELL_SIZE, noise ? $urandom : pick_cell_size());
		if ($urandom_range(0, 3) != 0)
			apb_access(1'b1, REG_GRID_WIDTH, noise ? $urandom : pick_width());
		if ($urandom_range(0, 3) != 0)
			apb_access(1'b1, REG_MAX_DISTANCE, noise ? $urandom : pick_max_distance());
		if ($urandom_range(0, 15) == 0)
			apb_access(1'b1, REG_UNUSED, $urandom);
		if ($urandom_range(0, 15) == 0)
			apb_access(1'b0, reg_idx_t'($urandom_range(0, 6)), '0);
	endtask

	task automatic retune();
		case ($urandom_range(0, 2))
			0:       apb_access(1'b1, REG_GRID_WIDTH, pick_width());
			1:       apb_access(1'b1, REG_MAX_DISTANCE, pick_max_distance());
			default: apb_access(1'b1, REG_CELL_SIZE, pick_cell_size());
		endcase
	endtask

	task automatic send_grid(input int cells, input int busy_pct, input int split);
		for (int n = 0; n < cells; n++) begin
			if (split > 0 && n == split) begin
				pause_until_idle();
				retune();
			end
			send_cell(pick_occupancy(busy_pct), n == cells - 1);
		end
	endtask

	task automatic send_long_grid(input int cells, input int first_busy);
		for (int n = 0; n < cells; n++)
			send_cell((n >= first_busy) ? 8'h5A : 8'h00, n == cells - 1);
	endtask

	initial begin
		int phase_grids;
		int cells;
		int split;
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		grid_bus.valid     = 1'b0;
		grid_bus.occupancy = '0;
		grid_bus.last_cell = 1'b0;
		burst_left         = 0;
		cells_sent         = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		read_all();
		send_cell(8'h00, 1'b0);
		send_cell(8'hFF, 1'b0);
		send_cell(8'h80, 1'b0);
		send_cell(8'h7F, 1'b0);
		send_cell(8'h01, 1'b0);
		send_cell(8'h64, 1'b1);
		send_cell(8'h00, 1'b1);
		send_cell(8'h05, 1'b1);
		pause_until_idle();

		// opposite corners: the sum of the two squares saturates
		apb_access(1'b1, REG_ROBOT_X, 32'h7FFF_FFFF);
		apb_access(1'b1, REG_ROBOT_Y, 32'h8000_0000);
		apb_access(1'b1, REG_GRID_ORIGIN_X, 32'h8000_0000);
		apb_access(1'b1, REG_GRID_ORIGIN_Y, 32'h7FFF_FFFF);
		apb_access(1'b1, REG_CELL_SIZE, 32'h00FF_FFFF);
		apb_access(1'b1, REG_GRID_WIDTH, 8191);
		apb_access(1'b1, REG_MAX_DISTANCE, 32'h00FF_FFFF);
		apb_access(1'b1, REG_UNUSED, 32'hFFFF_FFFF);
		read_all();
		send_cell(8'h7F, 1'b0);
		send_cell(8'h7F, 1'b1);
		pause_until_idle();

		apb_access(1'b1, REG_ROBOT_X, 32'h8000_0000);
		apb_access(1'b1, REG_ROBOT_Y, 32'h7FFF_FFFF);
		apb_access(1'b1, REG_GRID_ORIGIN_X, 32'h8000_0000);
		apb_access(1'b1, REG_GRID_ORIGIN_Y, 32'h7FFF_FFFF);
		apb_access(1'b1, REG_CELL_SIZE, 1);
		apb_access(1'b1, REG_GRID_WIDTH, 0);
		send_cell(8'h00, 1'b0);
		send_cell(8'h32, 1'b0);
		send_cell(8'h00, 1'b1);
		pause_until_idle();
		apb_access(1'b1, REG_MAX_DISTANCE, 0);
		send_cell(8'h7F, 1'b1);
		pause_until_idle();

		// equal distances, then width shrunk and limit rewritten mid-grid
		apb_access(1'b1, REG_ROBOT_X, 0);
		apb_access(1'b1, REG_ROBOT_Y, 0);
		apb_access(1'b1, REG_GRID_ORIGIN_X, 32'hFFFE_0000);
		apb_access(1'b1, REG_GRID_ORIGIN_Y, 0);
		apb_access(1'b1, REG_CELL_SIZE, 65536);
		apb_access(1'b1, REG_GRID_WIDTH, 5);
		apb_access(1'b1, REG_MAX_DISTANCE, 10 * 65536);
		send_cell(8'h0A, 1'b0);
		send_cell(8'h00, 1'b0);
		send_cell(8'h00, 1'b0);
		send_cell(8'h00, 1'b0);
		pause_until_idle();
		apb_access(1'b1, REG_GRID_WIDTH, 2);
		send_cell(8'h0A, 1'b0);
		send_cell(8'h00, 1'b0);
		pause_until_idle();
		apb_access(1'b1, REG_MAX_DISTANCE, 3 * 65536);
		send_cell(8'h00, 1'b1);
		pause_until_idle();

		// row counter wrap, then column wrap at full width
		apb_access(1'b1, REG_GRID_ORIGIN_X, 0);
		apb_access(1'b1, REG_ROBOT_Y, 100 * 65536);
		apb_access(1'b1, REG_GRID_WIDTH, 1);
		apb_access(1'b1, REG_MAX_DISTANCE, 32'h00FF_FFFF);
		send_long_grid(MAX_ROWS + 4, MAX_ROWS);
		pause_until_idle();
		apb_access(1'b1, REG_ROBOT_X, 100 * 65536);
		apb_access(1'b1, REG_ROBOT_Y, 0);
		apb_access(1'b1, REG_GRID_WIDTH, 0);
		send_long_grid(MAX_COLUMNS + 4, MAX_COLUMNS);

		while (cells_sent < RANDOM_CELLS) begin
			pause_until_idle();
			randomize_setup();
			phase_grids = $urandom_range(1, 4);
			repeat (phase_grids) begin
				cells = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 80) :
					$urandom_range(1, 24);
				split = (cells > 1 && $urandom_range(0, 7) == 0) ?
					$urandom_range(1, cells - 1) : 0;
				send_grid(cells, $urandom_range(0, 100), split);
				cells_sent += cells;
			end
		end

		pause_until_idle();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
